### design/bsa_pkg.sv
// ----------------------------------------------------------------------------
// Binary search package
// Payload types, command codes, controller states and the command/status
// structs shared by the controller and the datapath of the search block.
// ----------------------------------------------------------------------------
`default_nettype none

package bsa_pkg;

   // Width of the reported match index.
   localparam int PosW = 6;

   // Width of a stored element or search key.
   localparam int ValueW = 32;

   // Request command codes.
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   // One request: load an element or search for a key.
   typedef struct packed {
      logic                     command;
      logic signed [ValueW-1:0] value;
      logic                     new_array;
   } req_type;

   // One response: search outcome.
   typedef struct packed {
      logic            found;
      logic [PosW-1:0] position;
      logic            overflowed;
   } rsp_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_CHECK
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;         // store the accepted element
      logic start;        // latch key, open the full search range
      logic issue;        // read the middle element of the range
      logic compare;      // narrow the range around the probed element
      logic finish_hit;   // capture a found response
      logic finish_miss;  // capture a not-found response
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic range_empty;  // no elements left to probe
      logic hit;          // probed element equals the key
   } dp_status_type;

endpackage

`default_nettype wire

### design/bsa_dp.sv
// ----------------------------------------------------------------------------
// Binary search datapath
// Element store, element count, overflow flag, search bounds, probe read
// register and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_dp #(
   parameter int DEPTH = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire bsa_pkg::req_type       req_payload,
   input  wire bsa_pkg::dp_cmd_type    cmd,
   output bsa_pkg::dp_status_type      status,
   output bsa_pkg::rsp_type            rsp_payload
);

   localparam int CntW = $clog2(DEPTH + 1);
   localparam int IdxW = $clog2(DEPTH);

   // Element store, written by loads and read by probes.
   logic signed [bsa_pkg::ValueW-1:0] store_mem [DEPTH];

   logic [CntW-1:0] count_ff, count_in;
   logic            overflow_ff, overflow_in;

   logic signed [bsa_pkg::ValueW-1:0] key_ff;
   logic signed [bsa_pkg::ValueW-1:0] rd_data_ff;
   logic [CntW-1:0]                   lo_ff, lo_in;
   logic [CntW-1:0]                   hi_ff, hi_in;
   logic [IdxW-1:0]                   mid_ff;

   logic                              found_ff;
   logic [bsa_pkg::PosW-1:0]          position_ff;
   logic                              overflowed_ff;

   logic            room;
   logic            wr_en;
   logic [IdxW-1:0] wr_addr;
   logic [CntW:0]   mid_sum;
   logic [IdxW-1:0] mid_calc;

   // Load bookkeeping: a new array restarts at index zero.
   assign room    = (count_ff < CntW'(DEPTH));
   assign wr_en   = cmd.load && (req_payload.new_array || room);
   assign wr_addr = req_payload.new_array ? '0 : count_ff[IdxW-1:0];

   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (cmd.load) begin
         if (req_payload.new_array) begin
            count_in    = CntW'(1);
            overflow_in = 1'b0;
         end else if (room) begin
            count_in = count_ff + CntW'(1);
         end else begin
            overflow_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   // Store write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= req_payload.value;
      end
   end

   // Middle of the half-open range [lo, hi).
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff} - (CntW + 1)'(1);
   assign mid_calc = mid_sum[IdxW:1];

   // Range setup at search start, and range update after a probe that missed.
   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (cmd.start) begin
         lo_in = '0;
         hi_in = count_ff;
      end else if (cmd.compare) begin
         if (key_ff < rd_data_ff) begin
            hi_in = CntW'(mid_ff);
         end else begin
            lo_in = CntW'(mid_ff) + CntW'(1);
         end
      end
   end

   // Key and bounds registers.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         key_ff <= req_payload.value;
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

   // Store read port with registered data.
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         mid_ff     <= mid_calc;
         rd_data_ff <= store_mem[mid_calc];
      end
   end

   assign status.range_empty = (lo_ff >= hi_ff);
   assign status.hit         = (rd_data_ff == key_ff);

   // Response register.
   always_ff @(posedge clock) begin
      if (cmd.finish_hit) begin
         found_ff      <= 1'b1;
         position_ff   <= bsa_pkg::PosW'(mid_ff);
         overflowed_ff <= overflow_ff;
      end else if (cmd.finish_miss) begin
         found_ff      <= 1'b0;
         position_ff   <= '0;
         overflowed_ff <= overflow_ff;
      end
   end

   assign rsp_payload.found      = found_ff;
   assign rsp_payload.position   = position_ff;
   assign rsp_payload.overflowed = overflowed_ff;

endmodule

`default_nettype wire

### design/bsa_ctrl.sv
// ----------------------------------------------------------------------------
// Binary search controller
// Sequences loads and the probe loop of a search, and owns the response
// valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_command,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire bsa_pkg::dp_status_type status,
   output bsa_pkg::dp_cmd_type        cmd
);

   bsa_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   // State and response valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   // Next state and datapath commands.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = (state_ff != bsa_pkg::ST_IDLE);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         bsa_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_command == bsa_pkg::CMD_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = bsa_pkg::ST_ISSUE;
               end
            end
         end
         bsa_pkg::ST_ISSUE: begin
            // Range exhausted: the key is absent.
            if (status.range_empty) begin
               if (out_free) begin
                  cmd.finish_miss = 1'b1;
                  rsp_valid_in    = 1'b1;
                  state_in        = bsa_pkg::ST_IDLE;
               end
            end else begin
               cmd.issue = 1'b1;
               state_in  = bsa_pkg::ST_CHECK;
            end
         end
         bsa_pkg::ST_CHECK: begin
            if (status.hit) begin
               if (out_free) begin
                  cmd.finish_hit = 1'b1;
                  rsp_valid_in   = 1'b1;
                  state_in       = bsa_pkg::ST_IDLE;
               end
            end else begin
               cmd.compare = 1'b1;
               state_in    = bsa_pkg::ST_ISSUE;
            end
         end
         default: begin
            state_in = bsa_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### design/sorted_array_binary_search.sv
// ----------------------------------------------------------------------------
// Sorted array binary search
// A load request appends a signed element to the store (or starts a new
// array); loads past DEPTH are dropped and flag overflow. A search request
// bisects the stored elements and answers with found, position and the
// overflow flag. The store has one read port with registered data, and a
// search makes at most log2(DEPTH) + 1 probes. The response sits in an
// output register, so loads are taken while it waits. Store contents are
// undefined after reset; only written entries are read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_array_binary_search #(
   parameter int DEPTH = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire bsa_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output bsa_pkg::rsp_type      rsp_payload
);

   bsa_pkg::dp_cmd_type    cmd;
   bsa_pkg::dp_status_type status;

   // Control sequencer.
   bsa_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_payload.command),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .cmd         (cmd)
   );

   // Store, bounds and response register.
   bsa_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

   // The store is never read once the search range is empty.
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.issue && status.range_empty))
      else $error("probe issued on an empty range");

   // A response is only captured when the output register can take it.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.finish_hit || cmd.finish_miss) |-> (!rsp_valid || !rsp_stall))
      else $error("response captured over a pending response");

   // An accepted search keeps the block busy on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_payload.command == bsa_pkg::CMD_SEARCH)
      |=> req_stall)
      else $error("request taken during a search");

   // At most one datapath command is active per cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.start, cmd.issue, cmd.compare,
                cmd.finish_hit, cmd.finish_miss}))
      else $error("conflicting datapath commands");

endmodule

`default_nettype wire

### bench/sorted_array_binary_search_tb.sv
// ----------------------------------------------------------------------------
// Sorted array binary search testbench
// Streams load and search requests into the block and checks every search
// response against a cycle-free bisection kept alongside the block. The
// requests start with a short directed set of edge cases, then run through
// random arrays (sorted, duplicate-heavy, near the signed extremes, unsorted,
// and long enough to overflow the store), each followed by searches for
// present and absent keys. Both sides idle at random, and the receiver holds
// off once for a long stretch to back the block up.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_array_binary_search_tb;

   localparam int StoreDepth   = 64;
   localparam int RandomItems  = 1400;
   localparam int CycleLimit   = 400000;
   localparam int DrainCycles  = 40;
   localparam int HoldoffAfter = 150;
   localparam int HoldoffLen   = 300;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_stall;
   bsa_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall   = 1'b0;
   bsa_pkg::rsp_type rsp_payload;

   // Requests waiting to be offered, and search outcomes waiting to arrive.
   bsa_pkg::req_type pending_requests[$];
   bsa_pkg::rsp_type expected_outcomes[$];

   // Shadow copy of the block's element store.
   logic signed [bsa_pkg::ValueW-1:0] stored_elements [StoreDepth];
   int unsigned                       stored_count   = 0;
   logic                              loads_dropped  = 1'b0;

   int unsigned total_requests    = 0;
   int unsigned accepted_requests = 0;
   int unsigned loads_applied     = 0;
   int unsigned searches_applied  = 0;
   int unsigned responses_checked = 0;
   int unsigned hits_seen         = 0;
   int unsigned overflow_reports  = 0;
   int unsigned mismatch_count    = 0;
   int unsigned cycle_count       = 0;

   // Sender burst state and receiver stall state.
   int unsigned      burst_left   = 0;
   int unsigned      gap_left     = 0;
   int unsigned      holdoff_left = 0;
   logic             holdoff_done = 1'b0;
   int unsigned      stall_mode   = 0;
   int unsigned      mode_left    = 0;
   bsa_pkg::rsp_type oldest_outcome;

   sorted_array_binary_search #(
      .DEPTH(StoreDepth)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Apply one accepted request to the shadow store; a search queues the
   // outcome that bisection over the stored elements gives.
   task automatic apply_request(input bsa_pkg::req_type r);
      logic signed [bsa_pkg::ValueW-1:0] key;
      logic signed [bsa_pkg::ValueW-1:0] probe;
      int                                first;
      int                                last;
      int                                middle;
      bsa_pkg::rsp_type                  outcome;
      key = r.value;
      if (r.command == bsa_pkg::CMD_LOAD) begin
         loads_applied++;
         if (r.new_array) begin
            stored_count  = 0;
            loads_dropped = 1'b0;
         end
         if (stored_count < StoreDepth) begin
            stored_elements[stored_count] = key;
            stored_count++;
         end else begin
            loads_dropped = 1'b1;
         end
      end else begin
         searches_applied++;
         outcome = '0;
         first = 0;
         last  = int'(stored_count) - 1;
         while (first <= last && !outcome.found) begin
            middle = (first + last) / 2;
            probe  = stored_elements[middle];
            if (key < probe) begin
               last = middle - 1;
            end else if (key > probe) begin
               first = middle + 1;
            end else begin
               outcome.found    = 1'b1;
               outcome.position = middle[bsa_pkg::PosW-1:0];
            end
         end
         outcome.overflowed = loads_dropped;
         expected_outcomes.push_back(outcome);
      end
   endtask

   task automatic add_request(input logic cmd, input logic [bsa_pkg::ValueW-1:0] v,
                              input logic fresh);
      bsa_pkg::req_type r;
      r.command   = cmd;
      r.value     = v;
      r.new_array = fresh;
      pending_requests.push_back(r);
   endtask

   // Request driver: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_request(req_payload);
            accepted_requests++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               req_payload <= pending_requests.pop_front();
               req_valid   <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each response against the oldest expectation
   // and drives the stall pattern, including one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_outcomes.size() == 0) begin
               $error("Response with no search outstanding: found %0b position %0d",
                      rsp_payload.found, rsp_payload.position);
               mismatch_count++;
            end else begin
               oldest_outcome = expected_outcomes.pop_front();
               if (rsp_payload.found !== oldest_outcome.found) begin
                  $error("found: expected %0b, actual %0b",
                         oldest_outcome.found, rsp_payload.found);
                  mismatch_count++;
               end
               if (rsp_payload.position !== oldest_outcome.position) begin
                  $error("position: expected %0d, actual %0d",
                         oldest_outcome.position, rsp_payload.position);
                  mismatch_count++;
               end
               if (rsp_payload.overflowed !== oldest_outcome.overflowed) begin
                  $error("overflowed: expected %0b, actual %0b",
                         oldest_outcome.overflowed, rsp_payload.overflowed);
                  mismatch_count++;
               end
               responses_checked++;
               if (oldest_outcome.found) hits_seen++;
               if (oldest_outcome.overflowed) overflow_reports++;
            end
         end

         if (holdoff_left != 0) begin
            holdoff_left--;
            rsp_stall <= 1'b1;
         end else if (!holdoff_done && responses_checked >= HoldoffAfter) begin
            holdoff_done = 1'b1;
            holdoff_left = HoldoffLen - 1;
            rsp_stall   <= 1'b1;
         end else begin
            // Switch between no stall, light, heavy and alternating stalls.
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left  = $urandom_range(20, 200);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               0: begin
                  rsp_stall <= 1'b0;
               end
               1: begin
                  rsp_stall <= ($urandom_range(0, 3) == 0);
               end
               2: begin
                  rsp_stall <= ($urandom_range(0, 3) != 0);
               end
               default: begin
                  rsp_stall <= ~rsp_stall;
               end
            endcase
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Timed out after %0d cycles", CycleLimit);
         $display("Mismatches found");
         $finish;
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      logic signed [bsa_pkg::ValueW-1:0] elems[$];
      logic signed [bsa_pkg::ValueW-1:0] v;
      logic signed [bsa_pkg::ValueW-1:0] key;
      int                                len;
      int                                kind;
      int                                pos;
      int                                searches;

      // Searches on the empty store, one with new_array set.
      add_request(bsa_pkg::CMD_SEARCH, 32'h0000_0000, 1'b0);
      add_request(bsa_pkg::CMD_SEARCH, 32'h8000_0000, 1'b1);
      // The two signed extremes.
      add_request(bsa_pkg::CMD_LOAD, 32'h8000_0000, 1'b1);
      add_request(bsa_pkg::CMD_LOAD, 32'h7fff_ffff, 1'b0);
      add_request(bsa_pkg::CMD_SEARCH, 32'h8000_0000, 1'b0);
      add_request(bsa_pkg::CMD_SEARCH, 32'h7fff_ffff, 1'b0);
      add_request(bsa_pkg::CMD_SEARCH, 32'h0000_0000, 1'b0);
      add_request(bsa_pkg::CMD_SEARCH, 32'hffff_ffff, 1'b0);
      // Duplicates: the middle copy is the one probed first.
      add_request(bsa_pkg::CMD_LOAD, -32'sd5, 1'b1);
      add_request(bsa_pkg::CMD_LOAD, 32'sd3, 1'b0);
      add_request(bsa_pkg::CMD_LOAD, 32'sd3, 1'b0);
      add_request(bsa_pkg::CMD_LOAD, 32'sd3, 1'b0);
      add_request(bsa_pkg::CMD_LOAD, 32'sd9, 1'b0);
      add_request(bsa_pkg::CMD_SEARCH, 32'sd3, 1'b0);
      add_request(bsa_pkg::CMD_SEARCH, 32'sd9, 1'b0);
      add_request(bsa_pkg::CMD_SEARCH, -32'sd5, 1'b0);
      add_request(bsa_pkg::CMD_SEARCH, 32'sd4, 1'b0);
      add_request(bsa_pkg::CMD_SEARCH, -32'sd100, 1'b0);
      // Unsorted data can hide a key that is present.
      add_request(bsa_pkg::CMD_LOAD, 32'sd10, 1'b1);
      add_request(bsa_pkg::CMD_LOAD, 32'sd2, 1'b0);
      add_request(bsa_pkg::CMD_LOAD, 32'sd7, 1'b0);
      add_request(bsa_pkg::CMD_SEARCH, 32'sd2, 1'b0);
      add_request(bsa_pkg::CMD_SEARCH, 32'sd10, 1'b0);

      // Random arrays, each followed by a few searches.
      while (pending_requests.size() < RandomItems + 23) begin
         pos = $urandom_range(0, 99);
         if (pos < 3) begin
            len = $urandom_range(StoreDepth, StoreDepth + 6);
         end else if (pos < 13) begin
            len = $urandom_range(13, StoreDepth - 1);
         end else begin
            len = $urandom_range(1, 12);
         end
         kind = $urandom_range(0, 9);
         elems.delete();
         for (int i = 0; i < len; i++) begin
            if (kind < 6) begin
               v = $urandom;
            end else if (kind < 8) begin
               v = $urandom_range(0, 8);
               v = v - 32'sd4;
            end else if ($urandom_range(0, 1) == 1) begin
               v = 32'h7fff_ffff - $urandom_range(0, 3);
            end else begin
               v = 32'h8000_0000 + $urandom_range(0, 3);
            end
            // The last kind stays in arrival order; the rest are sorted.
            if (kind == 9) begin
               elems.push_back(v);
            end else begin
               pos = 0;
               while (pos < elems.size() && elems[pos] <= v) pos++;
               elems.insert(pos, v);
            end
         end
         for (int i = 0; i < len; i++) begin
            add_request(bsa_pkg::CMD_LOAD, elems[i], i == 0);
         end
         searches = $urandom_range(1, 6);
         for (int i = 0; i < searches; i++) begin
            case ($urandom_range(0, 3))
               0, 1: begin
                  key = elems[$urandom_range(0, len - 1)];
               end
               2: begin
                  key = elems[$urandom_range(0, len - 1)];
                  key = ($urandom_range(0, 1) == 1) ? key + 32'sd1 : key - 32'sd1;
               end
               default: begin
                  key = $urandom;
               end
            endcase
            add_request(bsa_pkg::CMD_SEARCH, key, 1'($urandom_range(0, 1)));
         end
         // Occasionally append to the array without restarting it.
         if ($urandom_range(0, 19) == 0) begin
            add_request(bsa_pkg::CMD_LOAD, $urandom, 1'b0);
            add_request(bsa_pkg::CMD_SEARCH, $urandom, 1'($urandom_range(0, 1)));
         end
      end
      total_requests = pending_requests.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (accepted_requests < total_requests) @(posedge clock);
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Ran %0d loads and %0d searches in %0d cycles.",
               loads_applied, searches_applied, cycle_count);
      $display("Searches: %0d hits, %0d misses, %0d reporting dropped loads.",
               hits_seen, responses_checked - hits_seen, overflow_reports);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire
